>>> hdl/convolution_2d_valid_defines.svh
// ----------------------------------------------------------------------------
// Convolution 2D valid - assertion macros
// Shared helpers for concurrent checks on clk_i with asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef CONVOLUTION_2D_VALID_DEFINES_SVH
`define CONVOLUTION_2D_VALID_DEFINES_SVH

// same-cycle implication
`define CV2_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CV2_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/cv2_pkg.sv
// ----------------------------------------------------------------------------
// Convolution 2D valid - package
// Sizes, codes and types shared by the convolution block.
// ----------------------------------------------------------------------------
package cv2_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_K      = 7;
  localparam int KK         = MAX_K * MAX_K;

  localparam int PIX_W   = 16;
  localparam int COEF_W  = 16;
  localparam int SUM_W   = 38;
  localparam int POS_W   = 10;
  localparam int DIM_W   = 11;
  localparam int KS_W    = 3;
  localparam int CI_W    = 6;
  localparam int PROD_W  = PIX_W + COEF_W + 1;
  localparam int SLOT_W  = $clog2(MAX_K);
  localparam int LS_DEPTH = MAX_K * MAX_WIDTH;
  localparam int LS_AW   = $clog2(LS_DEPTH);
  localparam int CT_AW   = $clog2(KK);

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_KSIZE  = 2'd2;

  // input item kinds
  localparam logic KIND_COEF  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_e;

endpackage

>>> hdl/cv2_ram.sv
// ----------------------------------------------------------------------------
// Convolution 2D valid - generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cv2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hdl/convolution_2d_valid.sv
// ----------------------------------------------------------------------------
// Convolution 2D valid - top level
// K x K valid-mode convolution over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries coefficient loads
//   (kind 0) and pixels (kind 1) in raster order. Output channel
//   (out_valid_o / out_stall_i) carries one window sum per full window,
//   with its column, row and an end-of-frame flag.
//   Config writes (cfg_we_i) set width, height and K; a write to any of
//   these restarts the frame. Write only while the block is idle.
// Flow:
//   Coefficient loads and pixels that complete no window are taken
//   whenever the block is idle. A pixel that completes a window stalls
//   the input until its sum is posted: one tap per cycle through the
//   single line store read port, then multiply and accumulate.
//   The result lands in an output register; the next item is taken while
//   it waits. If the receiver stalls, a finished sum holds in the drain
//   step and input stalls until the output register frees.
// Reset:
//   Counters at frame start, coefficients read as zero, registers at
//   256 x 256, K = 7. Line store content is don't care.
// ----------------------------------------------------------------------------
`include "convolution_2d_valid_defines.svh"

module convolution_2d_valid (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_index_i,
  input  logic [cv2_pkg::DIM_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              kind_i,
  input  logic [cv2_pkg::CI_W-1:0]          coef_index_i,
  input  logic signed [cv2_pkg::COEF_W-1:0] coef_value_i,
  input  logic [cv2_pkg::PIX_W-1:0]         pixel_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [cv2_pkg::SUM_W-1:0]  sum_o,
  output logic [cv2_pkg::POS_W-1:0]         out_col_o,
  output logic [cv2_pkg::POS_W-1:0]         out_row_o,
  output logic                              last_o
);

  localparam int LSA = cv2_pkg::LS_AW;

  // configuration registers
  logic [cv2_pkg::DIM_W-1:0] width_q, height_q;
  logic [cv2_pkg::KS_W-1:0]  ksize_q;

  // frame position
  logic [cv2_pkg::POS_W-1:0]  col_q, col_d, row_q, row_d;
  logic [cv2_pkg::SLOT_W-1:0] rslot_q, rslot_d;

  // window walk
  cv2_pkg::state_e state_q, state_d;
  logic [cv2_pkg::POS_W-1:0]  x_q, y_q;
  logic [cv2_pkg::KS_W-1:0]   k_q, kx_q, ky_q;
  logic [cv2_pkg::SLOT_W-1:0] slot_q;
  logic [cv2_pkg::CI_W-1:0]   ci_q;
  logic                       last_q;
  logic                       rd_v_q, mul_v_q, cok_q;
  logic signed [cv2_pkg::PROD_W-1:0] mul_q;
  logic signed [cv2_pkg::SUM_W-1:0]  acc_q;
  logic [cv2_pkg::KK-1:0]     cvalid_q;

  logic accept, is_pix, produce, issue, last_tap, deliver;
  logic [cv2_pkg::DIM_W-1:0] c1, r1;
  logic [3:0] top_sum;
  logic [cv2_pkg::SLOT_W-1:0] top_slot;
  logic [LSA-1:0] ls_waddr, ls_raddr;
  logic [cv2_pkg::PIX_W-1:0]  ls_rdata;
  logic [cv2_pkg::COEF_W-1:0] ct_rdata;
  logic signed [cv2_pkg::COEF_W-1:0] coef_eff;
  logic ct_we;

  assign in_stall_o = (state_q != cv2_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign is_pix     = (kind_i == cv2_pkg::KIND_PIXEL);
  assign c1         = {1'b0, col_q} + cv2_pkg::DIM_W'(1);
  assign r1         = {1'b0, row_q} + cv2_pkg::DIM_W'(1);
  assign produce    = (c1 >= cv2_pkg::DIM_W'(ksize_q)) && (r1 >= cv2_pkg::DIM_W'(ksize_q));
  assign top_sum    = 4'(rslot_q) + 4'(cv2_pkg::MAX_K) - 4'(ksize_q - 3'd1);
  assign top_slot   = (top_sum >= 4'(cv2_pkg::MAX_K)) ?
                      cv2_pkg::SLOT_W'(top_sum - 4'(cv2_pkg::MAX_K)) :
                      cv2_pkg::SLOT_W'(top_sum);
  assign issue      = (state_q == cv2_pkg::ST_RUN);
  assign last_tap   = (kx_q == k_q - 3'd1) && (ky_q == k_q - 3'd1);
  assign deliver    = (state_q == cv2_pkg::ST_DRAIN) && !rd_v_q && !mul_v_q &&
                      (!out_valid_o || !out_stall_i);

  // memory addresses
  assign ls_waddr = LSA'(rslot_q) * LSA'(cv2_pkg::MAX_WIDTH) + LSA'(col_q);
  assign ls_raddr = LSA'(slot_q) * LSA'(cv2_pkg::MAX_WIDTH) + LSA'(x_q) + LSA'(kx_q);
  assign ct_we    = accept && !is_pix && (coef_index_i < cv2_pkg::CI_W'(cv2_pkg::KK));

  cv2_ram #(.WIDTH(cv2_pkg::PIX_W), .DEPTH(cv2_pkg::LS_DEPTH)) u_line_store (
    .clk_i   (clk_i),
    .we_i    (accept && is_pix),
    .waddr_i (ls_waddr),
    .wdata_i (pixel_i),
    .raddr_i (ls_raddr),
    .rdata_o (ls_rdata)
  );

  cv2_ram #(.WIDTH(cv2_pkg::COEF_W), .DEPTH(cv2_pkg::KK)) u_coef_table (
    .clk_i   (clk_i),
    .we_i    (ct_we),
    .waddr_i (cv2_pkg::CT_AW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .raddr_i (cv2_pkg::CT_AW'(ci_q)),
    .rdata_o (ct_rdata)
  );

  assign coef_eff = cok_q ? $signed(ct_rdata) : '0;

  // next frame position
  always_comb begin
    col_d   = col_q;
    row_d   = row_q;
    rslot_d = rslot_q;
    if (c1 >= width_q) begin
      col_d = '0;
      if (r1 >= height_q) begin
        row_d   = '0;
        rslot_d = '0;
      end else begin
        row_d   = row_q + cv2_pkg::POS_W'(1);
        rslot_d = (rslot_q == cv2_pkg::SLOT_W'(cv2_pkg::MAX_K - 1)) ? '0 :
                  rslot_q + cv2_pkg::SLOT_W'(1);
      end
    end else begin
      col_d = col_q + cv2_pkg::POS_W'(1);
    end
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cv2_pkg::ST_IDLE:  if (accept && is_pix && produce) state_d = cv2_pkg::ST_RUN;
      cv2_pkg::ST_RUN:   if (last_tap) state_d = cv2_pkg::ST_DRAIN;
      cv2_pkg::ST_DRAIN: if (deliver) state_d = cv2_pkg::ST_IDLE;
      default:           state_d = cv2_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= cv2_pkg::DIM_W'(256);
      height_q    <= cv2_pkg::DIM_W'(256);
      ksize_q     <= cv2_pkg::KS_W'(7);
      col_q       <= '0;
      row_q       <= '0;
      rslot_q     <= '0;
      state_q     <= cv2_pkg::ST_IDLE;
      rd_v_q      <= 1'b0;
      mul_v_q     <= 1'b0;
      out_valid_o <= 1'b0;
      cvalid_q    <= '0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= issue;
      mul_v_q <= rd_v_q;
      if (ct_we) cvalid_q[cv2_pkg::CT_AW'(coef_index_i)] <= 1'b1;
      if (accept && is_pix) begin
        col_q   <= col_d;
        row_q   <= row_d;
        rslot_q <= rslot_d;
      end
      if (deliver) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      if (cfg_we_i && cfg_index_i <= cv2_pkg::REG_KSIZE) begin
        col_q   <= '0;
        row_q   <= '0;
        rslot_q <= '0;
        case (cfg_index_i)
          cv2_pkg::REG_WIDTH:
            width_q <= (cfg_data_i == '0) ? cv2_pkg::DIM_W'(1) :
                       (cfg_data_i > cv2_pkg::DIM_W'(cv2_pkg::MAX_WIDTH)) ?
                       cv2_pkg::DIM_W'(cv2_pkg::MAX_WIDTH) : cfg_data_i;
          cv2_pkg::REG_HEIGHT:
            height_q <= (cfg_data_i == '0) ? cv2_pkg::DIM_W'(1) :
                        (cfg_data_i > cv2_pkg::DIM_W'(cv2_pkg::MAX_HEIGHT)) ?
                        cv2_pkg::DIM_W'(cv2_pkg::MAX_HEIGHT) : cfg_data_i;
          cv2_pkg::REG_KSIZE:
            ksize_q <= (cfg_data_i[cv2_pkg::KS_W-1:0] == '0) ? cv2_pkg::KS_W'(1) :
                       cfg_data_i[cv2_pkg::KS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // window walk and datapath
  always_ff @(posedge clk_i) begin
    if (accept && is_pix && produce) begin
      x_q    <= cv2_pkg::POS_W'(c1 - cv2_pkg::DIM_W'(ksize_q));
      y_q    <= cv2_pkg::POS_W'(r1 - cv2_pkg::DIM_W'(ksize_q));
      k_q    <= ksize_q;
      kx_q   <= '0;
      ky_q   <= '0;
      ci_q   <= '0;
      slot_q <= top_slot;
      last_q <= (c1 == width_q) && (r1 == height_q);
      acc_q  <= '0;
    end
    if (issue) begin
      ci_q  <= ci_q + cv2_pkg::CI_W'(1);
      cok_q <= cvalid_q[cv2_pkg::CT_AW'(ci_q)];
      if (kx_q == k_q - 3'd1) begin
        kx_q   <= '0;
        ky_q   <= ky_q + 3'd1;
        slot_q <= (slot_q == cv2_pkg::SLOT_W'(cv2_pkg::MAX_K - 1)) ? '0 :
                  slot_q + cv2_pkg::SLOT_W'(1);
      end else begin
        kx_q <= kx_q + 3'd1;
      end
    end
    if (rd_v_q) mul_q <= $signed({1'b0, ls_rdata}) * coef_eff;
    if (mul_v_q) acc_q <= acc_q + {{(cv2_pkg::SUM_W-cv2_pkg::PROD_W){mul_q[cv2_pkg::PROD_W-1]}}, mul_q};
    if (deliver) begin
      sum_o     <= acc_q;
      out_col_o <= x_q;
      out_row_o <= y_q;
      last_o    <= last_q;
    end
  end

  // checks
  `CV2_ASSERT_IMP(a_pipe_busy, rd_v_q || mul_v_q, state_q != cv2_pkg::ST_IDLE, "pipe active while idle")
  `CV2_ASSERT_IMP(a_tap_range, issue, ci_q < cv2_pkg::CI_W'(cv2_pkg::KK), "tap index beyond kernel")
  `CV2_ASSERT_NXT(a_out_from_drain, deliver, out_valid_o && state_q == cv2_pkg::ST_IDLE, "result not posted")

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// Convolution 2D valid - testbench
// Drives kernel loads and raster pixel frames through several image and
// kernel geometries, predicts every window sum in the bench and checks
// each output transfer field by field, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

  typedef struct {
    logic                       kind;
    logic [cv2_pkg::CI_W-1:0]   cidx;
    logic [cv2_pkg::COEF_W-1:0] cval;
    logic [cv2_pkg::PIX_W-1:0]  pix;
  } item_t;

  typedef struct {
    logic [cv2_pkg::SUM_W-1:0] sum;
    logic [cv2_pkg::POS_W-1:0] col;
    logic [cv2_pkg::POS_W-1:0] row;
    logic                      last;
  } window_t;

  localparam int WD_LIMIT   = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = cv2_pkg::REG_WIDTH;
  logic [cv2_pkg::DIM_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic kind = cv2_pkg::KIND_PIXEL;
  logic [cv2_pkg::CI_W-1:0] coef_index = '0;
  logic signed [cv2_pkg::COEF_W-1:0] coef_value = '0;
  logic [cv2_pkg::PIX_W-1:0] pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [cv2_pkg::SUM_W-1:0] sum;
  logic [cv2_pkg::POS_W-1:0] out_col, out_row;
  logic last;

  convolution_2d_valid dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .coef_index_i(coef_index), .coef_value_i(coef_value),
    .pixel_i(pixel),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sum_o(sum), .out_col_o(out_col), .out_row_o(out_row), .last_o(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  item_t   pending_q[$];
  window_t window_q[$];
  int      errors = 0;
  int      windows_seen = 0;
  int      frames_seen = 0;
  int      pixels_sent = 0;
  bit      quiet = 1'b0;

  // bench copy of the block state
  int unsigned img_w, img_h, ksize, col_pos, row_pos;
  int          coefs[cv2_pkg::KK];
  logic [cv2_pkg::PIX_W-1:0] rows_mem[cv2_pkg::MAX_K][cv2_pkg::MAX_WIDTH];

  function automatic int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void model_cfg(logic [1:0] idx, logic [cv2_pkg::DIM_W-1:0] d);
    case (idx)
      cv2_pkg::REG_WIDTH:  img_w = clamp(d, 1, cv2_pkg::MAX_WIDTH);
      cv2_pkg::REG_HEIGHT: img_h = clamp(d, 1, cv2_pkg::MAX_HEIGHT);
      cv2_pkg::REG_KSIZE:  ksize = clamp(d[cv2_pkg::KS_W-1:0], 1, cv2_pkg::MAX_K);
      default: return;
    endcase
    col_pos = 0;
    row_pos = 0;
  endfunction

  // advance the bench state by one item, queue the window sum it completes
  function automatic void predict_window(item_t it);
    longint acc;
    int unsigned c, r, x, y;
    window_t w;
    c = col_pos;
    r = row_pos;
    if (it.kind == cv2_pkg::KIND_COEF) begin
      if (it.cidx < cv2_pkg::KK) coefs[it.cidx] = $signed(it.cval);
      return;
    end
    rows_mem[r % cv2_pkg::MAX_K][c] = it.pix;
    if (c + 1 >= ksize && r + 1 >= ksize) begin
      x = c + 1 - ksize;
      y = r + 1 - ksize;
      acc = 0;
      for (int ky = 0; ky < ksize; ky++)
        for (int kx = 0; kx < ksize; kx++)
          acc += longint'(rows_mem[(y + ky) % cv2_pkg::MAX_K][x + kx]) *
                 longint'(coefs[ky * ksize + kx]);
      w.sum  = acc[cv2_pkg::SUM_W-1:0];
      w.col  = x[cv2_pkg::POS_W-1:0];
      w.row  = y[cv2_pkg::POS_W-1:0];
      w.last = (c + 1 == img_w && r + 1 == img_h);
      window_q.insert(window_q.size(), w);
    end
    if (c + 1 >= img_w) begin
      col_pos = 0;
      row_pos = (r + 1 >= img_h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    $display("MISMATCH %s (window %0d)", msg, windows_seen);
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (quiet || p < 60) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: one transfer per accept, gaps drawn between them
  int gap_left = 0;
  always @(posedge clk) begin
    item_t it;
    logic  nxt_valid;
    nxt_valid = in_valid;
    if (in_valid && !in_stall) begin
      nxt_valid = 1'b0;
      gap_left = gap_len();
    end
    if (!nxt_valid && rst_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_q.size() > 0) begin
        it = pending_q.pop_front();
        kind <= it.kind;
        coef_index <= it.cidx;
        coef_value <= it.cval;
        pixel <= it.pix;
        nxt_valid = 1'b1;
      end
    end
    in_valid <= nxt_valid;
  end

  // receiver stall pattern
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      stall_left = gap_len();
      out_stall <= (stall_left > 0);
    end
  end

  // monitor: predict on input transfers, check on output transfers
  int idle_cycles = 0;
  always @(posedge clk) begin
    window_t w;
    if (rst_n) begin
      idle_cycles++;
      if (cfg_we) idle_cycles = 0;
      if (in_valid && !in_stall) begin
        idle_cycles = 0;
        predict_window('{kind, coef_index, coef_value, pixel});
      end
      if (out_valid && !out_stall) begin
        idle_cycles = 0;
        if (window_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result at col %0d row %0d",
                                    out_col, out_row));
        end else begin
          w = window_q.pop_front();
          if (sum !== w.sum)
            report_mismatch($sformatf("sum: got %0d expected %0d", sum, $signed(w.sum)));
          if (out_col !== w.col)
            report_mismatch($sformatf("out_col: got %0d expected %0d", out_col, w.col));
          if (out_row !== w.row)
            report_mismatch($sformatf("out_row: got %0d expected %0d", out_row, w.row));
          if (last !== w.last)
            report_mismatch($sformatf("last: got %0d expected %0d", last, w.last));
        end
        windows_seen++;
        if (last) frames_seen++;
      end
      if (idle_cycles >= WD_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles", WD_LIMIT);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // block until nothing is queued, in flight or waiting at the output
  task automatic wait_idle();
    repeat (2) @(posedge clk);
    while (pending_q.size() > 0 || in_valid || in_stall || out_valid ||
           window_q.size() > 0) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [cv2_pkg::DIM_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    model_cfg(idx, d);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(int w, int h, int k);
    wait_idle();
    write_reg(cv2_pkg::REG_WIDTH, cv2_pkg::DIM_W'(w));
    write_reg(cv2_pkg::REG_HEIGHT, cv2_pkg::DIM_W'(h));
    write_reg(cv2_pkg::REG_KSIZE, cv2_pkg::DIM_W'(k));
  endtask

  function automatic logic [cv2_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return cv2_pkg::PIX_W'($urandom);
    endcase
  endfunction

  function automatic logic [cv2_pkg::COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return cv2_pkg::COEF_W'($urandom);
    endcase
  endfunction

  function automatic void push_coef(int idx, logic [cv2_pkg::COEF_W-1:0] v);
    item_t it;
    it = '{cv2_pkg::KIND_COEF, cv2_pkg::CI_W'(idx), v, cv2_pkg::PIX_W'($urandom)};
    pending_q.insert(pending_q.size(), it);
  endfunction

  function automatic void push_pixel(logic [cv2_pkg::PIX_W-1:0] p);
    item_t it;
    it = '{cv2_pkg::KIND_PIXEL, cv2_pkg::CI_W'($urandom), cv2_pkg::COEF_W'($urandom), p};
    pending_q.insert(pending_q.size(), it);
    pixels_sent++;
  endfunction

  function automatic void load_kernel(int k);
    for (int i = 0; i < k * k; i++) push_coef(i, rand_coef());
  endfunction

  // n pixels of frames, with the odd coefficient load slipped in mid-frame
  function automatic void push_frames(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) push_coef($urandom_range(0, 63), rand_coef());
      push_pixel(rand_pixel());
    end
  endfunction

  initial begin
    int k, w, h, n, rand_items;
    img_w = 256; img_h = 256; ksize = 7; col_pos = 0; row_pos = 0;
    foreach (coefs[i]) coefs[i] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: 3x3 kernel on 5x4, extreme coefficients and pixels
    set_geometry(5, 4, 3);
    push_coef(0, 16'h8000);
    push_coef(8, 16'h7FFF);
    push_coef(4, 16'hFFFF);
    push_coef(49, 16'h1234);   // out of table, ignored
    push_coef(63, 16'h7FFF);   // out of table, ignored
    for (int i = 0; i < 20; i++) push_pixel((i % 3 == 0) ? 16'hFFFF : 16'h0000);

    // out-of-range register values saturate; kernel 0 becomes 1
    set_geometry(0, 'h7FF, 0);
    push_coef(0, 16'h4000);
    push_frames(40);

    // kernel larger than the image: pixels consumed, no results
    set_geometry(3, 4, 'h7FF);
    push_frames(24);

    // random geometries, some phases cut off mid-frame
    rand_items = 0;
    while (rand_items < 150) begin
      k = $urandom_range(1, 7);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      set_geometry(w, h, (int'($urandom_range(0, 255)) << 3) | k);
      quiet = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        load_kernel(k);
        rand_items += k * k;
      end
      n = w * h * $urandom_range(1, 2);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      push_frames(n);
      rand_items += n;
    end
    quiet = 1'b0;

    // largest geometry with a single tap, then a full 7x7 frame
    set_geometry(1024, 1024, 1);
    push_frames(30);
    set_geometry(7, 7, 7);
    load_kernel(7);
    push_frames(49);

    wait_idle();
    if (window_q.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", window_q.size()));
    end
    $display("Sent %0d pixels; checked %0d window sums over %0d complete frames",
             pixels_sent, windows_seen, frames_seen);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
